>>> src/bond_dilatation_accumulator_unit_macros.svh
// assertion macros for the bond dilatation accumulator
`ifndef BOND_DILATATION_ACCUMULATOR_UNIT_MACROS_SVH
`define BOND_DILATATION_ACCUMULATOR_UNIT_MACROS_SVH

// same-cycle implication on clk, disabled in reset
`define BDA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, disabled in reset
`define BDA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/bda_pkg.sv
// shared types and constants of the bond dilatation accumulator
package bda_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAG_W     = 62;
	localparam int SUB_W     = 36;
	localparam int DIV_W     = MAG_W + FRAC_BITS;
	localparam int CNT_W     = $clog2(DIV_W);
	localparam int ROOT_STEPS = 32;
	localparam int IN_W      = 280;

	localparam logic [63:0] MAG_SAT = (64'd1 << MAG_W) - 64'd1;
	localparam logic [63:0] HALF_LSB = 64'd1 << (FRAC_BITS - 1);
	localparam logic [31:0] PF_RESET = 32'd1 << FRAC_BITS;

	localparam logic REG_DIMENSION = 1'b0;
	localparam logic REG_PLANAR    = 1'b1;

	localparam logic [1:0] DIM_NONE = 2'd0;
	localparam logic [1:0] DIM_TWO  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ, ST_SQRT, ST_EXT, ST_MUL, ST_ACC, ST_NODE, ST_DIV, ST_FIN, ST_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] mul_a;
		logic [31:0] mul_b;
		logic [SUB_W-1:0] sub_a;
		logic [SUB_W-1:0] sub_b;
	} alu_req_t;

	typedef struct packed {
		logic [63:0] prod;
		logic [SUB_W-1:0] diff;
		logic ge;
	} alu_rsp_t;

	typedef struct packed {
		logic [1:0]  dim;
		logic [31:0] pf;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] ext;
		logic signed [31:0] dil;
		logic valid_dil;
		logic fault;
	} result_t;

	typedef struct packed {
		logic        last;
		logic [31:0] wv;
		logic [31:0] nv;
		logic [16:0] vc;
		logic signed [31:0] uz;
		logic signed [31:0] uy;
		logic signed [31:0] ux;
		logic signed [31:0] dz;
		logic signed [31:0] dy;
		logic signed [31:0] dx;
	} item_t;

endpackage

>>> src/bda_alu.sv
// shared multiply and trial-subtract unit
module bda_alu import bda_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [SUB_W:0] d;

	always_comb begin
		rsp.prod = 64'(req.mul_a) * 64'(req.mul_b);
		d = {1'b0, req.sub_a} - {1'b0, req.sub_b};
		rsp.diff = d[SUB_W-1:0];
		rsp.ge = ~d[SUB_W];
	end

endmodule

>>> src/bda_core.sv
// sequencer and datapath registers of the bond dilatation accumulator
module bda_core import bda_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    in_valid,
	input  item_t   in_item,
	output logic    in_ready,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	state_t state_q, state_d;
	alu_req_t req;
	alu_rsp_t rsp;

	logic [31:0] vmag_q [6];
	logic [16:0] vc_q;
	logic [31:0] nv_q;
	logic [31:0] wv_q;
	logic last_q;
	logic vec_q;
	logic [CNT_W-1:0] cnt_q;
	logic [63:0] acc_q;
	logic [63:0] sqn_q;
	logic [SUB_W-1:0] rem_q;
	logic [31:0] root_q;
	logic [31:0] lenx_q;
	logic [31:0] leny_q;
	logic signed [31:0] ext_q;
	logic signed [31:0] dil_q;
	logic fault_q;
	logic [1:0] midx_q;
	logic mstep_q;
	logic [63:0] ma_q;
	logic [63:0] plo_q;
	logic signed [63:0] sum_q;
	logic neg_q;
	logic [DIV_W-1:0] dnum_q;
	logic [DIV_W-1:0] quo_q;
	logic [31:0] drem_q;

	logic [2:0] vidx;
	logic [SUB_W-1:0] remsh;
	logic [31:0] root_nx;
	logic [32:0] dsh;
	logic [31:0] extmag;
	logic [31:0] mb;
	logic [95:0] full;
	logic [63:0] rnd;
	logic [63:0] mres;
	logic signed [64:0] sum_ext;
	logic signed [63:0] sum_nx;
	logic [63:0] sabs;
	logic [65:0] sd;
	logic [63:0] num;
	logic [32:0] qcap;
	logic signed [33:0] ldiff;

	bda_alu u_alu (.req(req), .rsp(rsp));

	function automatic logic [31:0] mag32(input logic signed [32:0] v);
		logic signed [31:0] s;
		if (v > 33'sd2147483647) s = 32'sh7FFFFFFF;
		else if (v < -33'sd2147483648) s = 32'sh80000000;
		else s = v[31:0];
		mag32 = s[31] ? 32'(-s) : 32'(s);
	endfunction

	always_comb begin
		vidx = vec_q ? 3'(3'd3 + 3'(cnt_q[1:0])) : 3'(cnt_q[1:0]);
		remsh = {rem_q[SUB_W-3:0], sqn_q[63:62]};
		root_nx = rsp.ge ? {root_q[30:0], 1'b1} : {root_q[30:0], 1'b0};
		dsh = {drem_q, dnum_q[DIV_W-1]};
		extmag = ext_q[31] ? 32'(-ext_q) : 32'(ext_q);
		case (midx_q)
			2'd0: mb = extmag;
			2'd1: mb = 32'(vc_q);
			2'd2: mb = nv_q;
			default: mb = cfg.pf;
		endcase
		full = {32'd0, plo_q} + {rsp.prod, 32'd0};
		rnd = (full[63:0] + HALF_LSB) >> FRAC_BITS;
		if (full[95:63] != 33'd0) mres = MAG_SAT;
		else if (rnd > MAG_SAT) mres = MAG_SAT;
		else mres = rnd;
		sum_ext = ext_q[31] ? (65'(sum_q) - $signed({1'b0, ma_q}))
			: (65'(sum_q) + $signed({1'b0, ma_q}));
		if (sum_ext > 65'sh0_7FFF_FFFF_FFFF_FFFF) sum_nx = 64'sh7FFF_FFFF_FFFF_FFFF;
		else if (sum_ext < -65'sh0_7FFF_FFFF_FFFF_FFFF) sum_nx = -64'sh7FFF_FFFF_FFFF_FFFF;
		else sum_nx = sum_ext[63:0];
		sabs = sum_q[63] ? 64'(-sum_q) : 64'(sum_q);
		sd = (cfg.dim[0] ? 66'(sabs) : 66'd0) + (cfg.dim[1] ? {1'b0, sabs, 1'b0} : 66'd0);
		num = (sd > 66'(MAG_SAT)) ? MAG_SAT : sd[63:0];
		qcap = (quo_q > DIV_W'(64'd1 << 32)) ? 33'h1_0000_0000 : quo_q[32:0];
		ldiff = $signed({2'b00, leny_q}) - $signed({2'b00, lenx_q});
	end

	always_comb begin
		req = '0;
		in_ready = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SQ: begin
				req.mul_a = vmag_q[vidx];
				req.mul_b = vmag_q[vidx];
			end
			ST_SQRT: begin
				req.sub_a = remsh;
				req.sub_b = SUB_W'({root_q, 2'b01});
			end
			ST_MUL: begin
				req.mul_a = mstep_q ? ma_q[63:32] : ma_q[31:0];
				req.mul_b = mb;
			end
			ST_DIV: begin
				req.sub_a = SUB_W'(dsh);
				req.sub_b = SUB_W'(wv_q);
			end
			ST_DONE: res_valid = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_SQ;
			ST_SQ: if (cnt_q == CNT_W'(2)) state_d = ST_SQRT;
			ST_SQRT: if (cnt_q == CNT_W'(ROOT_STEPS - 1)) state_d = vec_q ? ST_EXT : ST_SQ;
			ST_EXT: state_d = ST_MUL;
			ST_MUL: if (mstep_q) begin
				if (midx_q == 2'd3) state_d = ST_DIV;
				else if (midx_q == 2'd2) state_d = ST_ACC;
			end
			ST_ACC: state_d = last_q ? ST_NODE : ST_DONE;
			ST_NODE: begin
				if (wv_q == 32'd0 || cfg.dim == DIM_NONE) state_d = ST_DONE;
				else if (cfg.dim == DIM_TWO) state_d = ST_MUL;
				else state_d = ST_DIV;
			end
			ST_DIV: if (cnt_q == CNT_W'(DIV_W - 1)) state_d = ST_FIN;
			ST_FIN: state_d = ST_DONE;
			ST_DONE: if (res_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ACC) sum_q <= sum_nx;
			if (state_q == ST_NODE) sum_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				vmag_q[0] <= mag32(33'(in_item.dx));
				vmag_q[1] <= mag32(33'(in_item.dy));
				vmag_q[2] <= mag32(33'(in_item.dz));
				vmag_q[3] <= mag32(33'(in_item.dx) + 33'(in_item.ux));
				vmag_q[4] <= mag32(33'(in_item.dy) + 33'(in_item.uy));
				vmag_q[5] <= mag32(33'(in_item.dz) + 33'(in_item.uz));
				vc_q <= in_item.vc;
				nv_q <= in_item.nv;
				wv_q <= in_item.wv;
				last_q <= in_item.last;
				vec_q <= 1'b0;
				cnt_q <= '0;
				acc_q <= '0;
				dil_q <= '0;
				fault_q <= 1'b0;
			end
			ST_SQ: begin
				if (cnt_q == CNT_W'(2)) begin
					sqn_q <= acc_q + rsp.prod;
					rem_q <= '0;
					root_q <= '0;
					cnt_q <= '0;
				end else begin
					acc_q <= acc_q + rsp.prod;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_SQRT: begin
				rem_q <= rsp.ge ? rsp.diff : remsh;
				root_q <= root_nx;
				sqn_q <= {sqn_q[61:0], 2'b00};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
					cnt_q <= '0;
					acc_q <= '0;
					vec_q <= 1'b1;
					if (vec_q) leny_q <= root_nx;
					else lenx_q <= root_nx;
				end
			end
			ST_EXT: begin
				if (ldiff > 34'sd2147483647) ext_q <= 32'sh7FFFFFFF;
				else if (ldiff < -34'sd2147483648) ext_q <= 32'sh80000000;
				else ext_q <= ldiff[31:0];
				ma_q <= 64'(lenx_q);
				midx_q <= 2'd0;
				mstep_q <= 1'b0;
			end
			ST_MUL: begin
				mstep_q <= ~mstep_q;
				if (!mstep_q) begin
					plo_q <= rsp.prod;
				end else begin
					ma_q <= mres;
					midx_q <= midx_q + 2'd1;
					dnum_q <= {mres[MAG_W-1:0], {FRAC_BITS{1'b0}}};
					drem_q <= '0;
					quo_q <= '0;
					cnt_q <= '0;
				end
			end
			ST_NODE: begin
				neg_q <= sum_q[63];
				fault_q <= (wv_q == 32'd0);
				ma_q <= num;
				midx_q <= 2'd3;
				mstep_q <= 1'b0;
				dnum_q <= {num[MAG_W-1:0], {FRAC_BITS{1'b0}}};
				drem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				drem_q <= rsp.ge ? rsp.diff[31:0] : dsh[31:0];
				quo_q <= {quo_q[DIV_W-2:0], rsp.ge};
				dnum_q <= {dnum_q[DIV_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_FIN: begin
				if (!neg_q) dil_q <= (qcap > 33'h0_7FFF_FFFF) ? 32'sh7FFFFFFF : qcap[31:0];
				else dil_q <= (qcap >= 33'h0_8000_0000) ? 32'sh80000000 : 32'(-qcap[31:0]);
			end
			default: ;
		endcase
	end

	always_comb begin
		res.ext = ext_q;
		res.dil = dil_q;
		res.valid_dil = last_q;
		res.fault = fault_q;
	end

endmodule

>>> src/bond_dilatation_accumulator_unit.sv
// top level of the bond dilatation accumulator
// an accepted bond runs six squares, two 32-step square roots and three products; on a node's
// last bond a 78-step division may follow, preceded in two dimensions by the planar product
// one bond at a time: the next transaction is taken only once the result moves to the output
// register; reset clears the sum, config to defaults
module bond_dilatation_accumulator_unit import bda_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [31:0]     cfg_data,
	input  logic            s_tvalid,
	output logic            s_tready,
	// ref_dx, ref_dy, ref_dz, rel_ux, rel_uy, rel_uz, volume_correction,
	// neighbor_volume, weighted_volume, zero pad
	input  logic [IN_W-1:0] s_tdata,
	input  logic            s_tlast,
	output logic            m_tvalid,
	input  logic            m_tready,
	// bond_extension, node_dilatation
	output logic [63:0]     m_tdata,
	output logic            m_tlast,
	// divide_fault
	output logic            m_tuser
);

	cfg_t cfg_q;
	item_t item;
	result_t res;
	logic res_valid, res_ready;
	logic m_valid_q;
	logic [63:0] m_data_q;
	logic m_last_q, m_user_q;

	always_comb begin
		item = {s_tlast, s_tdata[272:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dim <= 2'd3;
			cfg_q.pf <= PF_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIMENSION: cfg_q.dim <= cfg_data[1:0];
				REG_PLANAR: cfg_q.pf <= cfg_data;
				default: ;
			endcase
		end
	end

	bda_core u_core (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(s_tvalid), .in_item(item), .in_ready(s_tready),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_data_q <= {res.dil, res.ext};
			m_last_q <= res.valid_dil;
			m_user_q <= res.fault;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;
	assign m_tlast = m_last_q;
	assign m_tuser = m_user_q;

endmodule

>>> src/bda_checker.sv
// port checker of the bond dilatation accumulator and its bind
`include "bond_dilatation_accumulator_unit_macros.svh"

module bda_port_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            s_tvalid,
	input logic            s_tready,
	input logic            m_tvalid,
	input logic            m_tready,
	input logic [63:0]     m_tdata,
	input logic            m_tlast,
	input logic            m_tuser
);

	`BDA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata), "output moved while stalled")
	`BDA_ASSERT_NXT(a_busy_after_take, s_tvalid && s_tready,
		!s_tready, "second transaction taken at once")
	`BDA_ASSERT_IMP(a_fault_on_last, m_tvalid && m_tuser,
		m_tlast && m_tdata[63:32] == 32'd0, "fault without zero dilatation on last bond")
	`BDA_ASSERT_IMP(a_dil_only_last, m_tvalid && !m_tlast,
		m_tdata[63:32] == 32'd0 && !m_tuser, "dilatation off the last bond")

endmodule

bind bond_dilatation_accumulator_unit bda_port_checker u_bda_checker (.*);
